>>> rtl/psh_pkg.sv
// shared widths, constants and unit handshake types for the polynomial string hash
package psh_pkg;

	localparam int DATA_W = 30;
	localparam int MOD_W  = 31;
	localparam int SYM_W  = 8;
	localparam int CNT_W  = 5;
	localparam int IDX_W  = 1;

	localparam logic [DATA_W-1:0] BASE_RESET = DATA_W'(31);
	localparam logic [MOD_W-1:0]  MOD_RESET  = MOD_W'(1000000009);
	localparam logic [MOD_W-1:0]  MOD_MIN    = MOD_W'(2);
	localparam logic [MOD_W-1:0]  MOD_MAX    = MOD_W'(1073741824);
	localparam logic [SYM_W-1:0]  CHAR_BIAS  = SYM_W'(96);

	localparam logic [CNT_W-1:0] FULL_STEPS = CNT_W'(DATA_W);
	localparam logic [CNT_W-1:0] TERM_STEPS = CNT_W'(SYM_W);

	localparam logic [IDX_W-1:0] REG_BASE    = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_MODULUS = IDX_W'(1);

	// launch of one modular multiply: a must already be below the modulus,
	// b is scanned msb first for nsteps bits
	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic [CNT_W-1:0]  nsteps;
	} mm_ctl_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] value;
	} mm_res_t;

endpackage

>>> rtl/psh_mulmod.sv
// bit-serial modular multiplier: one double-add-reduce step per cycle while busy
module psh_mulmod import psh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [MOD_W-1:0] modulus,
	input  mm_ctl_t          ctl,
	output mm_res_t          res
);

	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] a_q;
	logic [DATA_W-1:0] b_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [MOD_W-1:0]  dbl;
	logic [DATA_W-1:0] dbl_red;
	logic [MOD_W-1:0]  sum;
	logic [DATA_W-1:0] sum_red;

	// acc < m, so 2*acc < 2m and one subtract is enough; same after adding a
	always_comb begin
		dbl     = {acc_q, 1'b0};
		dbl_red = (dbl >= modulus) ? DATA_W'(dbl - modulus) : dbl[DATA_W-1:0];
		sum     = {1'b0, dbl_red} + (b_q[DATA_W-1] ? {1'b0, a_q} : '0);
		sum_red = (sum >= modulus) ? DATA_W'(sum - modulus) : sum[DATA_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= ctl.nsteps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q <= '0;
			a_q   <= ctl.a;
			b_q   <= ctl.b;
		end else if (busy_q) begin
			acc_q <= sum_red;
			b_q   <= {b_q[DATA_W-2:0], 1'b0};
		end
	end

	assign res.done  = done_q;
	assign res.value = acc_q;

endmodule

>>> rtl/polynomial_string_hash.sv
// top level of the polynomial rolling string hash
//
//  channel | signals                          | direction | beat taken when
//  --------+----------------------------------+-----------+---------------------------
//  in      | in_valid, in_stall, symbol, last | into block| in_valid && !in_stall
//  out     | out_valid, out_stall, hash,      | from block| out_valid && !out_stall
//          | done_res                         |           |
//  cfg     | cfg_we, cfg_index, cfg_data      | into block| cfg_we
//
//  a character runs the term reduction, term*power and power*base in turn, all on
//  the one bit-serial modular multiplier, then a finish state; the next beat is
//  taken only once the sequencer is back in idle
//  after a modulus write the next character first re-reduces hash and power
//  (states S_RED_H and S_RED_P), for that character only
//  reset is asynchronous, active low; it restores base 31, modulus 1000000009,
//  hash 0 and power 1
//  a result waiting under out_stall does not block the next input beat; only a
//  second finished result waits in the finish state until the output frees up
module polynomial_string_hash import psh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// input characters
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [SYM_W-1:0] symbol,
	input  logic             last,
	// running hash results
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DATA_W-1:0] hash,
	output logic              done_res,
	// register writes
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [MOD_W-1:0] cfg_data
);

	// sequencer, one state per pass through the shared multiplier, plus idle and finish
	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_RED_H  = 7'b0000010,  // hash mod m after a modulus change
		S_RED_P  = 7'b0000100,  // power mod m after a modulus change
		S_TERM   = 7'b0001000,  // |symbol - bias| mod m
		S_MUL_TP = 7'b0010000,  // term * power mod m
		S_MUL_PB = 7'b0100000,  // power * base mod m
		S_FIN    = 7'b1000000   // hash + term*power, hand off result
	} state_t;

	state_t            state_q;
	logic              go_q;

	// configuration, modulus kept already clamped to 2 .. 2^30
	logic [DATA_W-1:0] base_q;
	logic [MOD_W-1:0]  eff_mod_q;
	logic              dirty_q;   // modulus rewritten since the state was reduced

	// running state
	logic [DATA_W-1:0] hash_q;
	logic [DATA_W-1:0] power_q;

	// per-character working registers
	logic [SYM_W-1:0]  sym_q;
	logic              last_q;
	logic [DATA_W-1:0] term_q;
	logic [DATA_W-1:0] tp_q;

	// output register
	logic              out_valid_q;
	logic [DATA_W-1:0] out_hash_q;
	logic              out_done_q;

	mm_ctl_t           mm_ctl;
	mm_res_t           mm_res;

	logic              in_take;
	logic              out_take;
	logic              out_free;
	logic              sym_ge;
	logic [SYM_W-1:0]  sym_diff;
	logic [DATA_W-1:0] term_fix;
	logic [MOD_W-1:0]  fin_sum;
	logic [DATA_W-1:0] fin_red;
	logic [MOD_W-1:0]  cfg_mod_clamped;

	assign in_stall = (state_q != S_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || !out_stall;

	// signed offset from the bias taken as magnitude plus direction
	assign sym_ge   = (sym_q >= CHAR_BIAS);
	assign sym_diff = sym_ge ? (sym_q - CHAR_BIAS) : (CHAR_BIAS - sym_q);

	// symbols below the bias wrap to m - (|diff| mod m), zero stays zero
	assign term_fix = (sym_ge || (mm_res.value == '0)) ? mm_res.value :
		DATA_W'(eff_mod_q - {1'b0, mm_res.value});

	// both addends below m, one conditional subtract
	assign fin_sum = {1'b0, hash_q} + {1'b0, tp_q};
	assign fin_red = (fin_sum >= eff_mod_q) ? DATA_W'(fin_sum - eff_mod_q) :
		fin_sum[DATA_W-1:0];

	assign cfg_mod_clamped = (cfg_data < MOD_MIN) ? MOD_MIN :
		(cfg_data > MOD_MAX) ? MOD_MAX : cfg_data;

	// operand selection for the shared multiplier; reductions multiply by one
	always_comb begin
		mm_ctl.start  = go_q;
		mm_ctl.a      = DATA_W'(1);
		mm_ctl.b      = hash_q;
		mm_ctl.nsteps = FULL_STEPS;
		unique case (state_q)
			S_RED_H: begin
				mm_ctl.b = hash_q;
			end
			S_RED_P: begin
				mm_ctl.b = power_q;
			end
			S_TERM: begin
				mm_ctl.b      = {sym_diff, {(DATA_W-SYM_W){1'b0}}};
				mm_ctl.nsteps = TERM_STEPS;
			end
			S_MUL_TP: begin
				mm_ctl.a = power_q;
				mm_ctl.b = term_q;
			end
			S_MUL_PB: begin
				mm_ctl.a = power_q;
				mm_ctl.b = base_q;
			end
			default: begin
				mm_ctl.b = hash_q;
			end
		endcase
	end

	psh_mulmod u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.modulus (eff_mod_q),
		.ctl     (mm_ctl),
		.res     (mm_res)
	);

	// register writes, only while idle: the user must keep to this, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= BASE_RESET;
			eff_mod_q <= MOD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE:    base_q    <= cfg_data[DATA_W-1:0];
				REG_MODULUS: eff_mod_q <= cfg_mod_clamped;
				default:     base_q    <= base_q;
			endcase
		end
	end

	// sequencer and running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			go_q        <= 1'b0;
			dirty_q     <= 1'b0;
			hash_q      <= '0;
			power_q     <= DATA_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			go_q <= 1'b0;
			if (out_take) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we && (cfg_index == REG_MODULUS)) begin
				dirty_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						state_q <= dirty_q ? S_RED_H : S_TERM;
						go_q    <= 1'b1;
					end
				end
				S_RED_H: begin
					if (mm_res.done) begin
						hash_q  <= mm_res.value;
						state_q <= S_RED_P;
						go_q    <= 1'b1;
					end
				end
				S_RED_P: begin
					if (mm_res.done) begin
						power_q <= mm_res.value;
						dirty_q <= 1'b0;
						state_q <= S_TERM;
						go_q    <= 1'b1;
					end
				end
				S_TERM: begin
					if (mm_res.done) begin
						state_q <= S_MUL_TP;
						go_q    <= 1'b1;
					end
				end
				S_MUL_TP: begin
					if (mm_res.done) begin
						state_q <= S_MUL_PB;
						go_q    <= 1'b1;
					end
				end
				S_MUL_PB: begin
					if (mm_res.done) begin
						power_q <= mm_res.value;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						hash_q      <= last_q ? '0 : fin_red;
						if (last_q) begin
							power_q <= DATA_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// working and output payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			sym_q  <= symbol;
			last_q <= last;
		end
		if ((state_q == S_TERM) && mm_res.done) begin
			term_q <= term_fix;
		end
		if ((state_q == S_MUL_TP) && mm_res.done) begin
			tp_q <= mm_res.value;
		end
		if ((state_q == S_FIN) && out_free) begin
			out_hash_q <= fin_red;
			out_done_q <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign hash      = out_hash_q;
	assign done_res  = out_done_q;

	// multiplier only reports back during one of its passes
	a_done_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		mm_res.done |-> (state_q != S_IDLE) && (state_q != S_FIN))
		else $error("multiplier done outside a multiply pass");

	// clamped modulus stays in range
	a_mod_range: assert property (@(posedge clk) disable iff (!arst_n)
		(eff_mod_q >= MOD_MIN) && (eff_mod_q <= MOD_MAX))
		else $error("modulus out of clamped range");

	// idle state is fully reduced unless the modulus was just rewritten
	a_state_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_IDLE) && !dirty_q) |->
		(({1'b0, hash_q} < eff_mod_q) && ({1'b0, power_q} < eff_mod_q)))
		else $error("running state not below modulus");

	// a finished result always lands in the output register
	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_FIN) && out_free) |=> out_valid_q && (state_q == S_IDLE))
		else $error("finished result not handed to output");

	// every pass is launched exactly once on entry
	a_go_entry: assert property (@(posedge clk) disable iff (!arst_n)
		go_q |-> (state_q != $past(state_q)))
		else $error("multiplier launched without a state change");

endmodule

>>> sim/tb_polynomial_string_hash.sv
// self-checking testbench for polynomial_string_hash: directed and random strings against a predictor
`timescale 1ns / 100ps

module tb_polynomial_string_hash;
	import psh_pkg::*;

	// one result beat as the block should produce it
	typedef struct packed {
		logic [DATA_W-1:0] hash;
		logic              done;
	} hash_beat_t;

	// one row of the directed part; fixed rows carry a hand-computed hash
	typedef struct packed {
		logic [SYM_W-1:0]  sym;
		logic              lst;
		logic              fixed;
		logic [DATA_W-1:0] want;
	} char_row_t;

	localparam int NUM_PHASES  = 10;
	localparam int PHASE_CHARS = 190;

	// default config: base 31, modulus 1000000009, fresh string
	localparam char_row_t DIRECTED_CHARS [21] = '{
		'{8'd97,  1'b1, 1'b1, 30'd1},          // 'a' alone
		'{8'd96,  1'b1, 1'b1, 30'd0},          // one below 'a': zero term
		'{8'd0,   1'b1, 1'b1, 30'd999999913},  // lowest byte wraps below the modulus
		'{8'd255, 1'b1, 1'b1, 30'd159},        // highest byte
		'{8'd122, 1'b1, 1'b1, 30'd26},         // 'z'
		'{8'd95,  1'b1, 1'b1, 30'd1000000008}, // term of minus one
		'{8'd97,  1'b0, 1'b1, 30'd1},          // "abc"
		'{8'd98,  1'b0, 1'b1, 30'd63},
		'{8'd99,  1'b1, 1'b1, 30'd2946},
		'{8'd104, 1'b0, 1'b0, 30'd0},          // "hello"
		'{8'd101, 1'b0, 1'b0, 30'd0},
		'{8'd108, 1'b0, 1'b0, 30'd0},
		'{8'd108, 1'b0, 1'b0, 30'd0},
		'{8'd111, 1'b1, 1'b0, 30'd0},
		'{8'd65,  1'b0, 1'b0, 30'd0},          // uppercase, space and control bytes mid-string
		'{8'd32,  1'b0, 1'b0, 30'd0},
		'{8'd1,   1'b0, 1'b0, 30'd0},
		'{8'd128, 1'b0, 1'b0, 30'd0},
		'{8'hAA,  1'b0, 1'b0, 30'd0},
		'{8'h55,  1'b0, 1'b0, 30'd0},
		'{8'hFF,  1'b1, 1'b0, 30'd0}
	};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [SYM_W-1:0]  symbol;
	logic              last;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [DATA_W-1:0] hash;
	logic              done_res;
	logic              cfg_we;
	logic [IDX_W-1:0]  cfg_index;
	logic [MOD_W-1:0]  cfg_data;

	// predictor copy of the registers and the running state
	logic [DATA_W-1:0] base_cfg  = BASE_RESET;
	logic [MOD_W-1:0]  mod_cfg   = MOD_RESET;
	logic [DATA_W-1:0] run_hash  = '0;
	logic [DATA_W-1:0] run_power = DATA_W'(1);

	hash_beat_t pending_hashes [$];
	int         err_count    = 0;
	int         send_gap_pct = 0;
	int         stall_pct    = 0;
	int         stall_burst  = 0;

	polynomial_string_hash u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.symbol    (symbol),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hash      (hash),
		.done_res  (done_res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
		err_count++;
	endtask

	// advance the running hash by one character; the modulus in use is clamped
	// to 2 .. 2^30 and the stored state is re-reduced first, so a modulus
	// change in the middle of a string is covered
	function automatic hash_beat_t hash_char(input logic [SYM_W-1:0] sym, input logic lst);
		longint unsigned m;
		longint unsigned h;
		longint unsigned p;
		longint unsigned t;
		longint unsigned neg;
		hash_beat_t      r;
		m = 64'(mod_cfg);
		if (m < 64'(MOD_MIN)) m = 64'(MOD_MIN);
		if (m > 64'(MOD_MAX)) m = 64'(MOD_MAX);
		h = 64'(run_hash) % m;
		p = 64'(run_power) % m;
		// term is symbol minus the bias, folded into 0 .. m-1 when negative
		if (sym >= CHAR_BIAS) begin
			t = (64'(sym) - 64'(CHAR_BIAS)) % m;
		end else begin
			neg = (64'(CHAR_BIAS) - 64'(sym)) % m;
			t = (neg == 0) ? 64'd0 : m - neg;
		end
		h = (h + (t * p) % m) % m;
		p = (p * 64'(base_cfg)) % m;
		r.hash = h[DATA_W-1:0];
		r.done = lst;
		if (lst) begin
			run_hash  = '0;
			run_power = DATA_W'(1);
		end else begin
			run_hash  = h[DATA_W-1:0];
			run_power = p[DATA_W-1:0];
		end
		return r;
	endfunction

	// one register write; the caller lowers cfg_we after its last write
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [MOD_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		if (idx == REG_BASE)
			base_cfg = data[DATA_W-1:0];
		else
			mod_cfg = data;
	endtask

	// present one character beat, with an optional sender gap in front of it;
	// the expectation is queued at the edge that takes the beat
	task automatic send_char(input logic [SYM_W-1:0] sym, input logic lst, input logic fixed,
			input logic [DATA_W-1:0] want);
		hash_beat_t pred;
		int         gap;
		if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
			// long enough gaps to land anywhere in the processing of a character
			gap = $urandom_range(1, 150);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		symbol   <= sym;
		last     <= lst;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pred = hash_char(sym, lst);
		if (fixed) pred.hash = want;
		pending_hashes.push_back(pred);
	endtask

	// wait until every queued hash came back, then wait on so that the
	// block is surely back in idle before any register write
	task automatic drain;
		in_valid <= 1'b0;
		while (pending_hashes.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// receiver: random stall cycles plus rare long bursts, so a finished hash
	// sometimes waits past the next character
	always @(posedge clk) begin
		if (stall_burst != 0) begin
			stall_burst <= stall_burst - 1;
			out_stall   <= 1'b1;
		end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			out_stall <= 1'b1;
			if ($urandom_range(0, 199) == 0) stall_burst <= $urandom_range(20, 200);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// result checker: every accepted beat against the oldest expected hash
	always @(posedge clk) begin : check_hashes
		hash_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_hashes.size() == 0) begin
				report_mismatch("result beat with nothing expected", 32'(hash), 32'd0);
			end else begin
				want = pending_hashes.pop_front();
				if (hash !== want.hash)
					report_mismatch("hash", 32'(hash), 32'(want.hash));
				if (done_res !== want.done)
					report_mismatch("done_res", 32'(done_res), 32'(want.done));
			end
		end
	end

	initial begin : stimulus
		logic [MOD_W-1:0] base_w;
		logic [MOD_W-1:0] mod_w;
		logic [SYM_W-1:0] sym;
		logic             lst;
		int               str_left;
		in_valid  = 1'b0;
		symbol    = '0;
		last      = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_BASE;
		cfg_data  = '0;
		arst_n    = 1'b0;
		str_left  = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed characters on the reset configuration, no idling
		foreach (DIRECTED_CHARS[i])
			send_char(DIRECTED_CHARS[i].sym, DIRECTED_CHARS[i].lst,
				DIRECTED_CHARS[i].fixed, DIRECTED_CHARS[i].want);

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			drain();
			// register settings: reset values, typical primes, both ends of
			// each range and out-of-range moduli that get clamped
			case (phase)
				0: begin base_w = 31'd31;         mod_w = 31'd1000000009; end
				1: begin base_w = 31'd53;         mod_w = 31'd1000000007; end
				2: begin base_w = 31'd2;          mod_w = 31'd2;          end
				3: begin base_w = 31'h7FFF_FFFF;  mod_w = 31'h4000_0000;  end
				4: begin base_w = 31'd0;          mod_w = 31'd0;          end
				5: begin base_w = 31'd1;          mod_w = 31'd1;          end
				6: begin base_w = 31'($urandom()); mod_w = 31'h7FFF_FFFF; end
				7: begin base_w = 31'($urandom()); mod_w = 31'($urandom_range(3, 300)); end
				8: begin
					base_w = 31'($urandom_range(2, 1073741823));
					mod_w  = 31'($urandom_range(2, 1073741824));
				end
				default: begin base_w = 31'($urandom()); mod_w = 31'($urandom()); end
			endcase
			// strings stay open across the write, so the modulus often changes mid-string
			if (phase[0]) begin
				write_reg(REG_BASE, base_w);
				write_reg(REG_MODULUS, mod_w);
			end else begin
				write_reg(REG_MODULUS, mod_w);
				write_reg(REG_BASE, base_w);
			end
			cfg_we <= 1'b0;

			// idling: none, sender only, receiver only, both
			case (phase % 4)
				0: begin send_gap_pct = 0;  stall_pct = 0;  end
				1: begin send_gap_pct = 64; stall_pct = 0;  end
				2: begin send_gap_pct = 0;  stall_pct = 64; end
				default: begin send_gap_pct = 37; stall_pct = 37; end
			endcase

			// mostly lowercase words of random length, some raw bytes, and
			// now and then a string cut short
			for (int n = 0; n < PHASE_CHARS; n++) begin
				if (str_left == 0)
					str_left = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 24);
				if ($urandom_range(0, 4) == 0)
					sym = SYM_W'($urandom());
				else
					sym = SYM_W'($urandom_range(97, 122));
				lst = (str_left == 1) || ($urandom_range(0, 49) == 0);
				str_left = lst ? 0 : str_left - 1;
				send_char(sym, lst, 1'b0, '0);
			end
		end

		drain();
		repeat (160) @(posedge clk);
		if (err_count == 0)
			$display("tb_polynomial_string_hash: clean");
		else
			$display("tb_polynomial_string_hash: errors");
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#60_000_000;
		$display("tb_polynomial_string_hash: errors");
		$finish;
	end

endmodule

>>> polynomial_string_hash.f
rtl/psh_pkg.sv
rtl/psh_mulmod.sv
rtl/polynomial_string_hash.sv
sim/tb_polynomial_string_hash.sv
